### design/dmc_pkg.sv
// Shared types, codes and helpers for the maze carver.
package dmc_pkg;

  localparam int SIDE_BITS = 6;
  localparam int ADDR_BITS = 2 * SIDE_BITS;
  localparam int SIZE_BITS = SIDE_BITS + 1;
  localparam logic [SIZE_BITS-1:0] MIN_SIDE = 7'd3;
  localparam logic [SIZE_BITS-1:0] MAX_SIDE = 7'd64;
  localparam logic [SIZE_BITS-1:0] SIDE_RESET = 7'd15;

  typedef logic [SIDE_BITS-1:0] coord_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [SIZE_BITS-1:0] size_t;

  localparam logic [1:0] CMD_CARVE   = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [1:0] DIR_ROW_INC = 2'd0;
  localparam logic [1:0] DIR_COL_INC = 2'd1;
  localparam logic [1:0] DIR_ROW_DEC = 2'd2;
  localparam logic [1:0] DIR_COL_DEC = 2'd3;

  localparam logic [2:0] ST_UNUSED    = 3'd0;
  localparam logic [2:0] ST_BLOCKED   = 3'd1;
  localparam logic [2:0] ST_CARVED    = 3'd2;
  localparam logic [2:0] ST_BACKTRACK = 3'd3;
  localparam logic [2:0] ST_COMPLETE  = 3'd4;
  localparam logic [2:0] ST_READ      = 3'd5;
  localparam logic [2:0] ST_RESTARTED = 3'd6;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;

  localparam coord_t START_COORD = 6'd1;

  typedef struct packed {
    logic [3:0] free_dirs;
    logic       linked;
    logic [1:0] back_dir;
  } cell_t;

  localparam int CELL_BITS = $bits(cell_t);

  typedef struct packed {
    logic  en;
    addr_t addr;
    cell_t data;
  } cell_wr_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    logic  data;
  } carve_wr_t;

  function automatic size_t clamp_side(input size_t v);
    if (v < MIN_SIDE) return MIN_SIDE;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

endpackage

### design/dfs_maze_carver.sv
// Maze carver top level: size registers, walk sequencer and grid memories.
// The result strobe is registered in the evaluate state, or in the neighbor state when a carve
// examines a neighbor; a restart registers it on acceptance. A new request is taken only in idle,
// after the cell memory read and the read-modify-write of the neighbor entry are through.
// Reset and restart run a clearing sweep over all 4096 entries with busy high; size
// registers reset to 15 and are kept by restart. Results cannot be stalled.
module dfs_maze_carver
  import dmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [1:0] draw,
  input  coord_t     row_sel,
  input  coord_t     col_sel,
  output logic       strobe,
  output logic [2:0] status,
  output coord_t     opened_row,
  output coord_t     opened_col,
  output coord_t     here_row,
  output coord_t     here_col,
  output logic       is_wall,
  output logic       finished,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  size_t      cfg_data
);

  size_t     grid_rows, grid_cols;
  size_t     rows_eff, cols_eff;
  addr_t     cell_raddr, carve_raddr;
  cell_t     cell_rdata;
  logic      carve_rdata;
  cell_wr_t  cell_wr;
  carve_wr_t carve_wr;

  assign cfg_ready = 1'b1;
  assign rows_eff  = clamp_side(grid_rows);
  assign cols_eff  = clamp_side(grid_cols);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= SIDE_RESET;
      grid_cols <= SIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS: grid_rows <= cfg_data;
        REG_COLS: grid_cols <= cfg_data;
        default: ;
      endcase
    end
  end

  dmc_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .draw        (draw),
    .row_sel     (row_sel),
    .col_sel     (col_sel),
    .rows        (rows_eff),
    .cols        (cols_eff),
    .cell_raddr  (cell_raddr),
    .cell_rdata  (cell_rdata),
    .cell_wr     (cell_wr),
    .carve_raddr (carve_raddr),
    .carve_rdata (carve_rdata),
    .carve_wr    (carve_wr),
    .strobe      (strobe),
    .status      (status),
    .opened_row  (opened_row),
    .opened_col  (opened_col),
    .here_row    (here_row),
    .here_col    (here_col),
    .is_wall     (is_wall),
    .finished    (finished)
  );

  dmc_ram #(.W(CELL_BITS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_wr.en),
    .waddr (cell_wr.addr),
    .wdata (cell_wr.data),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  dmc_ram #(.W(1)) u_carve_ram (
    .clk   (clk),
    .we    (carve_wr.en),
    .waddr (carve_wr.addr),
    .wdata (carve_wr.data),
    .raddr (carve_raddr),
    .rdata (carve_rdata)
  );

endmodule

### design/dmc_ram.sv
// Single-port-write, single-port-read synchronous RAM, registered read.
module dmc_ram
  import dmc_pkg::*;
#(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         we,
  input  addr_t        waddr,
  input  logic [W-1:0] wdata,
  input  addr_t        raddr,
  output logic [W-1:0] rdata
);

  logic [W-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/dmc_walker.sv
// Walk sequencer: clearing sweep, carve/backtrack/read steps over the grid memories.
module dmc_walker
  import dmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  logic [1:0] cmd,
  input  logic [1:0] draw,
  input  coord_t    row_sel,
  input  coord_t    col_sel,
  input  size_t     rows,
  input  size_t     cols,
  output addr_t     cell_raddr,
  input  cell_t     cell_rdata,
  output cell_wr_t  cell_wr,
  output addr_t     carve_raddr,
  input  logic      carve_rdata,
  output carve_wr_t carve_wr,
  output logic      strobe,
  output logic [2:0] status,
  output coord_t    opened_row,
  output coord_t    opened_col,
  output coord_t    here_row,
  output coord_t    here_col,
  output logic      is_wall,
  output logic      finished
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EVAL, S_NBR} state_t;

  state_t     state;
  addr_t      clr_addr;
  coord_t     cur_row, cur_col;
  logic       done_flag;
  logic [1:0] op_cmd, op_draw;
  coord_t     op_rsel, op_csel;
  coord_t     nbr_row, nbr_col, mid_row, mid_col;

  logic [3:0] dbit;
  logic       step_ok;
  coord_t     step_row, step_col, step_mrow, step_mcol;
  coord_t     back_row, back_col;
  logic       read_wall;
  logic       nbr_open;

  assign busy = (state != S_IDLE);
  assign dbit = 4'b0001 << op_draw;

  always_comb begin
    step_ok   = 1'b0;
    step_row  = cur_row;
    step_col  = cur_col;
    step_mrow = cur_row;
    step_mcol = cur_col;
    case (op_draw)
      DIR_ROW_INC: begin
        step_ok   = ({1'b0, cur_row} + 7'd2) < rows;
        step_row  = cur_row + 6'd2;
        step_mrow = cur_row + 6'd1;
      end
      DIR_COL_INC: begin
        step_ok   = ({1'b0, cur_col} + 7'd2) < cols;
        step_col  = cur_col + 6'd2;
        step_mcol = cur_col + 6'd1;
      end
      DIR_ROW_DEC: begin
        step_ok   = cur_row >= 6'd2;
        step_row  = cur_row - 6'd2;
        step_mrow = cur_row - 6'd1;
      end
      default: begin
        step_ok   = cur_col >= 6'd2;
        step_col  = cur_col - 6'd2;
        step_mcol = cur_col - 6'd1;
      end
    endcase
  end

  always_comb begin
    back_row = cur_row;
    back_col = cur_col;
    case (cell_rdata.back_dir)
      DIR_ROW_INC: if (cur_row >= 6'd2) back_row = cur_row - 6'd2;
      DIR_COL_INC: if (cur_col >= 6'd2) back_col = cur_col - 6'd2;
      DIR_ROW_DEC: back_row = cur_row + 6'd2;
      default:     back_col = cur_col + 6'd2;
    endcase
  end

  always_comb begin
    if (({1'b0, op_rsel} >= rows) || ({1'b0, op_csel} >= cols)) begin
      read_wall = 1'b1;
    end else begin
      read_wall = !((op_rsel[0] && op_csel[0]) || carve_rdata);
    end
    nbr_open = (nbr_row[0] && nbr_col[0]) || carve_rdata;
  end

  // memory addressing and write-back
  always_comb begin
    cell_raddr  = {cur_row, cur_col};
    carve_raddr = {row_sel, col_sel};
    if (state == S_EVAL) begin
      cell_raddr  = {step_row, step_col};
      carve_raddr = {step_row, step_col};
    end
    cell_wr  = '0;
    carve_wr = '0;
    unique case (state)
      S_CLEAR: begin
        cell_wr.en             = 1'b1;
        cell_wr.addr           = clr_addr;
        cell_wr.data.free_dirs = 4'hF;
        cell_wr.data.linked    = (clr_addr == {START_COORD, START_COORD});
        cell_wr.data.back_dir  = 2'd0;
        carve_wr.en            = 1'b1;
        carve_wr.addr          = clr_addr;
        carve_wr.data          = 1'b0;
      end
      S_EVAL: begin
        cell_wr.addr           = {cur_row, cur_col};
        cell_wr.data           = cell_rdata;
        cell_wr.data.free_dirs = cell_rdata.free_dirs & ~dbit;
        cell_wr.en = (op_cmd == CMD_CARVE) && !done_flag &&
                     (cell_rdata.free_dirs != 4'd0) &&
                     ((cell_rdata.free_dirs & dbit) != 4'd0);
      end
      S_NBR: begin
        cell_wr.addr          = {nbr_row, nbr_col};
        cell_wr.data          = cell_rdata;
        cell_wr.data.linked   = 1'b1;
        cell_wr.data.back_dir = op_draw;
        cell_wr.en            = !cell_rdata.linked && nbr_open;
        carve_wr.addr         = {mid_row, mid_col};
        carve_wr.data         = 1'b1;
        carve_wr.en           = cell_wr.en;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      cur_row   <= START_COORD;
      cur_col   <= START_COORD;
      done_flag <= 1'b0;
      strobe    <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op_cmd  <= cmd;
            op_draw <= draw;
            op_rsel <= row_sel;
            op_csel <= col_sel;
            if (cmd == CMD_RESTART) begin
              state      <= S_CLEAR;
              clr_addr   <= '0;
              cur_row    <= START_COORD;
              cur_col    <= START_COORD;
              done_flag  <= 1'b0;
              strobe     <= 1'b1;
              status     <= ST_RESTARTED;
              opened_row <= '0;
              opened_col <= '0;
              here_row   <= START_COORD;
              here_col   <= START_COORD;
              is_wall    <= 1'b0;
              finished   <= 1'b0;
            end else begin
              state <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          state      <= S_IDLE;
          strobe     <= 1'b1;
          status     <= ST_UNUSED;
          opened_row <= '0;
          opened_col <= '0;
          here_row   <= cur_row;
          here_col   <= cur_col;
          is_wall    <= 1'b0;
          finished   <= done_flag;
          nbr_row    <= step_row;
          nbr_col    <= step_col;
          mid_row    <= step_mrow;
          mid_col    <= step_mcol;
          if (op_cmd == CMD_READ) begin
            status  <= ST_READ;
            is_wall <= read_wall;
          end else if (op_cmd == CMD_CARVE) begin
            if (done_flag) begin
              status <= ST_COMPLETE;
            end else if (cell_rdata.free_dirs == 4'd0) begin
              if (cur_row == START_COORD && cur_col == START_COORD) begin
                done_flag <= 1'b1;
                finished  <= 1'b1;
                status    <= ST_COMPLETE;
              end else begin
                cur_row  <= back_row;
                cur_col  <= back_col;
                here_row <= back_row;
                here_col <= back_col;
                if (back_row == START_COORD && back_col == START_COORD) begin
                  done_flag <= 1'b1;
                  finished  <= 1'b1;
                  status    <= ST_COMPLETE;
                end else begin
                  status <= ST_BACKTRACK;
                end
              end
            end else if ((cell_rdata.free_dirs & dbit) == 4'd0) begin
              status <= ST_UNUSED;
            end else if (!step_ok) begin
              status <= ST_BLOCKED;
            end else begin
              strobe <= 1'b0;
              state  <= S_NBR;
            end
          end
        end
        S_NBR: begin
          state      <= S_IDLE;
          strobe     <= 1'b1;
          opened_row <= '0;
          opened_col <= '0;
          here_row   <= cur_row;
          here_col   <= cur_col;
          is_wall    <= 1'b0;
          finished   <= done_flag;
          if (cell_wr.en) begin
            status     <= ST_CARVED;
            opened_row <= mid_row;
            opened_col <= mid_col;
            here_row   <= nbr_row;
            here_col   <= nbr_col;
            cur_row    <= nbr_row;
            cur_col    <= nbr_col;
          end else begin
            status <= ST_BLOCKED;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == S_EVAL || state == S_NBR ||
                     (state == S_IDLE && start && cmd == CMD_RESTART)))
    else $error("result strobe without a finished step");
  a_no_wr_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !cell_wr.en && !carve_wr.en)
    else $error("memory write while idle");
  a_walk_odd: assert property (@(posedge clk) disable iff (rst)
    cur_row[0] && cur_col[0])
    else $error("walk left the odd lattice");
  a_link_carve: assert property (@(posedge clk) disable iff (rst)
    (state == S_NBR) |-> (cell_wr.en == carve_wr.en))
    else $error("link and wall opening out of step");
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    ($past(done_flag) && !done_flag) |-> state == S_CLEAR)
    else $error("finished dropped without restart");
`endif

endmodule
